// ===== hw/rtl/adadelta_parameter_update_defines.svh =====
// Assertion macros shared by the Adadelta update RTL.
`ifndef ADADELTA_PARAMETER_UPDATE_DEFINES_SVH
`define ADADELTA_PARAMETER_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define ADU_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ADU_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ADU_ASSERT_IMPL(label, clk, rst_n, prop)
`define ADU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/adu_pkg.sv =====
// Package with shared types and constants of the Adadelta update block.
package adu_pkg;
	localparam int unsigned NumParams = 4096;
	localparam int unsigned IdxW = 12;
	localparam int unsigned AccW = 48;

	localparam logic [0:0] RegDecay = 1'b0;
	localparam logic [0:0] RegEps = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SQG,
		ST_RHOG,
		ST_OMRG,
		ST_RATIO,
		ST_DIV,
		ST_SQRT,
		ST_MAG,
		ST_SQU,
		ST_RHOX,
		ST_OMRX,
		ST_DONE
	} state_t;

	// Serial multiplier control and status.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [95:0] prod;
	} mul_rsp_t;
endpackage

// ===== hw/rtl/adu_ram.sv =====
// Generic single-port RAM with registered read.
module adu_ram #(
	parameter int unsigned Width = 48,
	parameter int unsigned Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== hw/rtl/adu_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`include "adadelta_parameter_update_defines.svh"
module adu_mul
	import adu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);
	logic [95:0] acc_q;
	logic [95:0] mcand_q;
	logic [31:0] mplier_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= {32'd0, req.a};
			mplier_q <= req.b;
		end else if (run_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[94:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[31:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	`ADU_ASSERT_IMPL(a_done_after_run, clk, arst_n, done_q |-> $past(run_q))
	`ADU_ASSERT_NEVER(a_no_restart, clk, arst_n, req.start && run_q)
	`ADU_ASSERT_IMPL(a_done_pulse, clk, arst_n, done_q |=> !done_q)
endmodule

// ===== hw/rtl/adadelta_parameter_update.sv =====
// Sequence: an accepted item passes through seven bit-serial multiplies, a 64-step divider
// and a 32-step square root before result_valid is strobed; the divider is skipped when the
// ratio is clipped. busy is high from acceptance to the strobe.
// One item is in flight at a time; a new item is taken only once busy is low. No result stall.
// Reset: decay_rate 62259, epsilon 4295; busy then stays high while both average RAMs are
// cleared to zero.
`include "adadelta_parameter_update_defines.svh"
module adadelta_parameter_update
	import adu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [IdxW-1:0]        param_index,
	input  logic signed [31:0]     gradient,
	input  logic signed [31:0]     old_weight,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	output logic                   result_valid,
	output logic signed [31:0]     new_weight,
	output logic signed [31:0]     update_value,
	output logic                   saturated
);
	state_t state_q, state_d;

	logic [15:0]     decay_q;
	logic [31:0]     eps_q;
	logic [IdxW-1:0] idx_q;
	logic            gneg_q;
	logic [31:0]     gmag_q;
	logic [31:0]     wraw_q;
	logic [AccW-1:0] eg_q, ex_q, egn_q, exn_q;
	logic [AccW-1:0] sq_q;
	logic [63:0]     part_q;
	logic [48:0]     den_q;
	logic [48:0]     rem_q;
	logic [63:0]     divd_q;
	logic [63:0]     quo_q;
	logic [63:0]     res_q;
	logic [63:0]     one_q;
	logic [5:0]      step_q;
	logic [31:0]     umag_q;
	logic            sat_q;
	logic [IdxW-1:0] clr_q;

	logic            we;
	logic [IdxW-1:0] addr;
	logic [AccW-1:0] wdata_eg, wdata_ex;
	logic [AccW-1:0] eg_rd, ex_rd;
	mul_req_t        mreq;
	mul_rsp_t        mrsp;

	logic [16:0]     one_minus_rho;
	logic [63:0]     sq_round;
	logic [64:0]     blend_sum;
	logic [AccW-1:0] blend_res;
	logic [48:0]     num_w;
	logic [48:0]     den_w;
	logic            ratio_clip;
	logic [49:0]     rem_sh;
	logic [49:0]     rem_diff;
	logic            div_take;
	logic [64:0]     sqrt_sum;
	logic            sqrt_take;
	logic [63:0]     mag_w;
	logic [39:0]     mag_m;
	logic            mag_clip;
	logic [31:0]     mag_sat;
	logic [31:0]     upd_w;
	logic [32:0]     nw_w;
	logic            nw_clip;

	assign addr = (state_q == ST_CLEAR) ? clr_q : idx_q;
	assign we = (state_q == ST_CLEAR) || (state_q == ST_DONE);
	assign wdata_eg = (state_q == ST_CLEAR) ? '0 : egn_q;
	assign wdata_ex = (state_q == ST_CLEAR) ? '0 : exn_q;

	adu_ram #(.Width(AccW), .Depth(NumParams)) u_eg_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata_eg), .rdata(eg_rd)
	);
	adu_ram #(.Width(AccW), .Depth(NumParams)) u_ex_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata_ex), .rdata(ex_rd)
	);

	adu_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	assign one_minus_rho = 17'h1_0000 - {1'b0, decay_q};
	assign sq_round = mrsp.prod[63:0] + 64'h8000;
	// The rho term waits in part_q while the (1-rho) term is formed.
	assign blend_sum = {1'b0, part_q} + {1'b0, mrsp.prod[63:0]} + 65'h8000;
	assign blend_res = blend_sum[63:16];

	assign num_w = {1'b0, ex_q} + {17'd0, eps_q};
	assign den_w = {1'b0, egn_q} + {17'd0, eps_q};
	// The quotient needs more than 64 bits exactly when num >> 16 reaches den.
	assign ratio_clip = ({16'd0, num_w[48:16]} >= den_w);

	assign rem_sh = {rem_q, divd_q[63]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign div_take = (rem_sh >= {1'b0, den_q});

	assign sqrt_sum = {1'b0, res_q} + {1'b0, one_q};
	assign sqrt_take = ({1'b0, quo_q} >= sqrt_sum);

	assign mag_w = mrsp.prod[63:0] + 64'h80_0000;
	assign mag_m = mag_w[63:24];
	assign mag_clip = gneg_q ? (mag_m > 40'h00_7FFF_FFFF) : (mag_m > 40'h00_8000_0000);
	assign mag_sat = mag_clip ? (gneg_q ? 32'h7FFF_FFFF : 32'h8000_0000) : mag_m[31:0];

	assign upd_w = gneg_q ? umag_q : (32'd0 - umag_q);
	assign nw_w = {wraw_q[31], wraw_q} + {upd_w[31], upd_w};
	assign nw_clip = (nw_w[32] != nw_w[31]);

	always_comb begin
		state_d = state_q;
		mreq = '0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IdxW'(NumParams - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_SQG;
				mreq.start = 1'b1;
				mreq.a = {32'd0, gmag_q};
				mreq.b = gmag_q;
			end
			ST_SQG: begin
				if (mrsp.done) begin
					state_d = ST_RHOG;
					mreq.start = 1'b1;
					mreq.a = {16'd0, eg_q};
					mreq.b = {16'd0, decay_q};
				end
			end
			ST_RHOG: begin
				if (mrsp.done) begin
					state_d = ST_OMRG;
					mreq.start = 1'b1;
					mreq.a = {16'd0, sq_q};
					mreq.b = {15'd0, one_minus_rho};
				end
			end
			ST_OMRG: begin
				if (mrsp.done) begin
					state_d = ST_RATIO;
				end
			end
			ST_RATIO: begin
				state_d = ratio_clip ? ST_SQRT : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == 6'd63) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (one_q == '0) begin
					state_d = ST_MAG;
					mreq.start = 1'b1;
					mreq.a = {32'd0, gmag_q};
					mreq.b = res_q[31:0];
				end
			end
			ST_MAG: begin
				if (mrsp.done) begin
					state_d = ST_SQU;
					mreq.start = 1'b1;
					mreq.a = {32'd0, mag_sat};
					mreq.b = mag_sat;
				end
			end
			ST_SQU: begin
				if (mrsp.done) begin
					state_d = ST_RHOX;
					mreq.start = 1'b1;
					mreq.a = {16'd0, ex_q};
					mreq.b = {16'd0, decay_q};
				end
			end
			ST_RHOX: begin
				if (mrsp.done) begin
					state_d = ST_OMRX;
					mreq.start = 1'b1;
					mreq.a = {16'd0, sq_q};
					mreq.b = {15'd0, one_minus_rho};
				end
			end
			ST_OMRX: begin
				if (mrsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			decay_q <= 16'd62259;
			eps_q   <= 32'd4295;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IdxW'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					RegDecay: decay_q <= cfg_data[15:0];
					RegEps: eps_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					idx_q  <= param_index;
					gneg_q <= gradient[31];
					gmag_q <= gradient[31] ? (32'd0 - gradient) : gradient;
					wraw_q <= old_weight;
					sat_q  <= 1'b0;
				end
			end
			ST_SQG: begin
				// The RAM output holds this item's averages from the first cycle here.
				eg_q <= eg_rd;
				ex_q <= ex_rd;
				if (mrsp.done) begin
					sq_q <= sq_round[63:16];
				end
			end
			ST_RHOG, ST_RHOX: begin
				if (mrsp.done) begin
					part_q <= mrsp.prod[63:0];
				end
			end
			ST_OMRG: begin
				if (mrsp.done) begin
					egn_q <= blend_res;
				end
			end
			ST_RATIO: begin
				den_q  <= den_w;
				rem_q  <= {16'd0, num_w[48:16]};
				divd_q <= {num_w[15:0], 48'd0};
				quo_q  <= ratio_clip ? '1 : '0;
				step_q <= '0;
				res_q  <= '0;
				one_q  <= 64'h4000_0000_0000_0000;
				if (ratio_clip) begin
					sat_q <= 1'b1;
				end
			end
			ST_DIV: begin
				rem_q  <= div_take ? rem_diff[48:0] : rem_sh[48:0];
				divd_q <= {divd_q[62:0], 1'b0};
				quo_q  <= {quo_q[62:0], div_take};
				step_q <= step_q + 6'd1;
			end
			ST_SQRT: begin
				if (one_q != '0) begin
					if (sqrt_take) begin
						quo_q <= quo_q - sqrt_sum[63:0];
						res_q <= {1'b0, res_q[63:1]} + one_q;
					end else begin
						res_q <= {1'b0, res_q[63:1]};
					end
					one_q <= {2'b00, one_q[63:2]};
				end
			end
			ST_MAG: begin
				if (mrsp.done) begin
					umag_q <= mag_sat;
					if (mag_clip) begin
						sat_q <= 1'b1;
					end
				end
			end
			ST_SQU: begin
				if (mrsp.done) begin
					sq_q <= sq_round[63:16];
				end
			end
			ST_OMRX: begin
				if (mrsp.done) begin
					exn_q <= blend_res;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);
	assign new_weight = nw_clip ? (nw_w[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : nw_w[31:0];
	assign update_value = upd_w;
	assign saturated = sat_q | nw_clip;

	`ADU_ASSERT_IMPL(a_start_reads, clk, arst_n,
		(start && !busy) |=> (state_q == ST_READ))
	`ADU_ASSERT_IMPL(a_done_one_cycle, clk, arst_n, result_valid |=> !result_valid)
	`ADU_ASSERT_NEVER(a_write_when_idle, clk, arst_n, we && state_q == ST_IDLE)
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the Adadelta parameter update block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import adu_pkg::*;

	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned RANDOM_ITEMS = 480;

	typedef struct {
		logic signed [31:0] weight;
		logic signed [31:0] step;
		logic               clipped;
	} adadelta_result_t;

	class adadelta_scoreboard;
		logic [AccW-1:0] grad_avg [NumParams];
		logic [AccW-1:0] step_avg [NumParams];
		logic [15:0] rho;
		logic [31:0] eps;
		adadelta_result_t pending_results[$];
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned clipped_seen;

		function new();
			foreach (grad_avg[i]) begin
				grad_avg[i] = '0;
				step_avg[i] = '0;
			end
			rho = 16'd62259;
			eps = 32'd4295;
			mismatches = 0;
			results_seen = 0;
			clipped_seen = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [31:0] value);
			if (idx == RegDecay)
				rho = value[15:0];
			else
				eps = value;
		endfunction

		function longint unsigned square_q32(longint unsigned mag);
			return (mag * mag + 64'h8000) >> 16;
		endfunction

		function logic [AccW-1:0] decay_mix(logic [AccW-1:0] prev, longint unsigned sq);
			logic [79:0] sum;
			sum = 80'(rho) * 80'(prev) + (80'd65536 - 80'(rho)) * 80'(sq);
			return AccW'((sum + 80'h8000) >> 16);
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= x)
					root = trial;
			end
			return root;
		endfunction

		// Works out the result of one accepted item and advances the accumulators.
		function void note_item(logic [IdxW-1:0] idx, logic signed [31:0] g,
				logic signed [31:0] w);
			adadelta_result_t res;
			longint unsigned gmag, num, den, q, m;
			logic [AccW-1:0] eg_new, ex_new, ex_old;
			logic [127:0] wide;
			longint signed upd, nw;
			logic sat;
			sat = 1'b0;
			gmag = g[31] ? (64'h1_0000_0000 - {32'b0, g}) : {32'b0, g};
			ex_old = step_avg[idx];
			eg_new = decay_mix(grad_avg[idx], square_q32(gmag));
			num = 64'(ex_old) + 64'(eps);
			den = 64'(eg_new) + 64'(eps);
			if (den == 0 || num / den >= 64'd65536) begin
				q = '1;
				sat = 1'b1;
			end else begin
				wide = {64'b0, num} << 48;
				q = 64'(wide / {64'b0, den});
			end
			wide = 128'(gmag) * 128'(int_sqrt(q)) + 128'h80_0000;
			wide = wide >> 24;
			if (g[31]) begin
				if (wide > 128'h7FFF_FFFF) begin
					wide = 128'h7FFF_FFFF;
					sat = 1'b1;
				end
			end else if (wide > 128'h8000_0000) begin
				wide = 128'h8000_0000;
				sat = 1'b1;
			end
			m = 64'(wide);
			upd = g[31] ? longint'(m) : -longint'(m);
			ex_new = decay_mix(ex_old, square_q32(m));
			grad_avg[idx] = eg_new;
			step_avg[idx] = ex_new;
			nw = longint'(w) + upd;
			if (nw > 64'sd2147483647) begin
				nw = 64'sd2147483647;
				sat = 1'b1;
			end else if (nw < -64'sd2147483648) begin
				nw = -64'sd2147483648;
				sat = 1'b1;
			end
			res.weight = nw[31:0];
			res.step = upd[31:0];
			res.clipped = sat;
			pending_results.push_back(res);
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic signed [31:0] nw, logic signed [31:0] uv, logic sat);
			adadelta_result_t exp_res;
			results_seen++;
			if (pending_results.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			exp_res = pending_results.pop_front();
			if (exp_res.clipped)
				clipped_seen++;
			if (nw !== exp_res.weight)
				report($sformatf("new_weight %h, expected %h", nw, exp_res.weight));
			if (uv !== exp_res.step)
				report($sformatf("update_value %h, expected %h", uv, exp_res.step));
			if (sat !== exp_res.clipped)
				report($sformatf("saturated %b, expected %b", sat, exp_res.clipped));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [IdxW-1:0] param_index = '0;
	logic signed [31:0] gradient = '0;
	logic signed [31:0] old_weight = '0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = RegDecay;
	logic [31:0] cfg_data = '0;
	logic result_valid;
	logic signed [31:0] new_weight;
	logic signed [31:0] update_value;
	logic saturated;

	adadelta_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned phases_run = 0;

	always #6 clk = ~clk;

	adadelta_parameter_update i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.param_index(param_index), .gradient(gradient), .old_weight(old_weight),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .new_weight(new_weight),
		.update_value(update_value), .saturated(saturated)
	);

	// A result and a new item never fall on one edge, as busy is high with result_valid; the result is checked first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(new_weight, update_value, saturated);
			if (start && !busy)
				sb.note_item(param_index, gradient, old_weight);
			if (result_valid || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > IDLE_LIMIT) begin
			$display("timeout: no item or result for %0d cycles", IDLE_LIMIT);
			$display("adadelta_parameter_update verification failed");
			$finish;
		end
	end

	// Leaves start high; the caller lowers it when a gap follows.
	task send_item(logic [IdxW-1:0] idx, logic signed [31:0] g, logic signed [31:0] w);
		start <= 1'b1;
		param_index <= idx;
		gradient <= g;
		old_weight <= w;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task pause(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (busy || sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task write_reg(logic [0:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	function logic signed [31:0] random_gradient();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	function logic signed [31:0] random_weight();
		case ($urandom_range(0, 3))
			0: return 32'sh7FFF_FFFF - $urandom_range(0, 1 << 24);
			1: return 32'sh8000_0000 + $urandom_range(0, 1 << 24);
			default: return $urandom;
		endcase
	endfunction

	task random_phase(int unsigned count);
		logic [IdxW-1:0] idx;
		int unsigned burst;
		while (count > 0) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && count > 0) begin
				// Mostly a few parameters, so the running averages build up.
				idx = ($urandom_range(0, 3) == 0) ? IdxW'($urandom) : IdxW'($urandom_range(0, 7));
				send_item(idx, random_gradient(), random_weight());
				burst--;
				count--;
			end
			if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 40));
		end
		drain();
	endtask

	initial begin
		logic [15:0] rho_val;
		logic [31:0] eps_val;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// Directed items at the reset settings: field extremes and sign cases.
		send_item(12'd0, 32'sd0, 32'sd0);
		send_item(12'hFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_item(12'd1, 32'sh8000_0000, 32'sh8000_0000);
		send_item(12'd2, -32'sd1, 32'sh7FFF_FFFF);
		send_item(12'd2, 32'sd1, 32'sh8000_0000);
		send_item(12'd3, 32'sh0100_0000, 32'sh8000_0000);
		send_item(12'd3, -32'sh0100_0000, 32'sh7FFF_FFF0);
		send_item(12'hAAA, 32'sh5555_5555, -32'sd1);
		send_item(12'h555, 32'shAAAA_AAAA, 32'sh5555_5555);
		drain();
		phases_run++;

		// With no decay and no epsilon: a zero denominator, a zero ratio on a large gradient,
		// then zero denominators again on the same parameter once the gradient is small.
		write_reg(RegDecay, 32'd0);
		write_reg(RegEps, 32'd0);
		send_item(12'd20, 32'sd0, 32'sd0);
		send_item(12'd21, 32'sh0400_0000, 32'sd0);
		send_item(12'd21, 32'sd0, 32'sd0);
		send_item(12'd21, 32'sd1, 32'sd100);
		drain();
		write_reg(RegEps, 32'hFFFF_FFFF);
		write_reg(RegDecay, 32'd65535);
		send_item(12'd22, 32'sh7FFF_FFFF, 32'sd0);
		send_item(12'd22, 32'sh8000_0000, 32'sd0);
		send_item(12'd23, 32'sd0, 32'sh7FFF_FFFF);
		drain();
		phases_run++;

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin rho_val = 16'd62259; eps_val = 32'd4295; end
				1: begin rho_val = 16'd0; eps_val = 32'd1; end
				2: begin rho_val = 16'hFFFF; eps_val = 32'hFFFF_FFFF; end
				3: begin rho_val = 16'h8000; eps_val = 32'd1; end
				default: begin rho_val = $urandom; eps_val = $urandom_range(1, 1 << 20); end
			endcase
			write_reg(RegDecay, {16'b0, rho_val});
			write_reg(RegEps, eps_val);
			random_phase(RANDOM_ITEMS / 6);
			phases_run++;
		end

		drain();
		repeat (400) @(posedge clk);
		$display("Run covered %0d items and %0d results over %0d settings phases.",
			items_sent, sb.results_seen, phases_run);
		$display("Saturated results expected: %0d.", sb.clipped_seen);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("adadelta_parameter_update verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.pending_results.size());
			$display("adadelta_parameter_update verification failed");
		end
		$finish;
	end
endmodule
